/* rtl/bapr_pkg.sv */
// Package for the advertising report parser.
// Holds the header codes, field type codes and field widths; no dependencies.
package bapr_pkg;

  localparam int unsigned PosWidth   = 9;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned AddrWidth  = 48;
  localparam int unsigned MaxNameDef = 30;

  // Header bytes and positions
  localparam logic [7:0] PktTypeEvent   = 8'h04;
  localparam logic [7:0] EvtLeMeta      = 8'h3E;
  localparam logic [7:0] SubAdvReport   = 8'h02;
  localparam logic [PosWidth-1:0] PosType    = 9'd0;
  localparam logic [PosWidth-1:0] PosEvent   = 9'd1;
  localparam logic [PosWidth-1:0] PosSubEvt  = 9'd3;
  localparam logic [PosWidth-1:0] PosAddrLo  = 9'd7;
  localparam logic [PosWidth-1:0] PosAddrHi  = 9'd12;
  localparam logic [PosWidth-1:0] PosDataLen = 9'd13;
  localparam logic [PosWidth-1:0] PosData    = 9'd14;
  localparam logic [PosWidth-1:0] PosSat     = 9'd511;

  // AD field types that carry the device name
  localparam logic [7:0] AdShortName    = 8'h08;
  localparam logic [7:0] AdCompleteName = 8'h09;

  // Result kinds
  localparam logic KindNameByte = 1'b0;
  localparam logic KindSummary  = 1'b1;

endpackage

/* rtl/ble_adv_report_parser.sv */
// Advertising report parser: one byte in per cycle, name bytes and a summary out.
// The result of a byte transfer is loaded into the output register at that transfer.
// Throughput: 1 byte per cycle; the only stall is a held output the sink does not take.
// Reset (rst_ni low, asynchronous): parse state returns to the start of a packet,
//   header marked as matching, all captured fields zero, output register empty.
// Depends on bapr_pkg.
module ble_adv_report_parser
  import bapr_pkg::*;
#(
  parameter int unsigned MAX_NAME = MaxNameDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    packet_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    kind_o,
  output logic [7:0]              name_byte_o,
  output logic [CountWidth-1:0]   name_index_o,
  output logic [AddrWidth-1:0]    device_address_o,
  output logic signed [7:0]       signal_strength_o,
  output logic [CountWidth-1:0]   name_length_o,
  output logic                    name_found_o,
  output logic                    rssi_present_o
);

  localparam logic [CountWidth-1:0] MaxNameC = CountWidth'(MAX_NAME);

  // Parse state, updated on every input transfer
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic                  hdr_q, hdr_d;
  logic [AddrWidth-1:0]  addr_q, addr_d;
  logic [7:0]            len_q, len_d;
  logic [PosWidth-1:0]   nfo_q, nfo_d;       // offset of the next AD length byte
  logic [7:0]            fls_q, fls_d;       // length of the current AD field
  logic                  stop_q, stop_d;
  logic                  in_name_q, in_name_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  seen_q, seen_d;
  logic [7:0]            rssi_q, rssi_d;
  logic                  rssi_ok_q, rssi_ok_d;

  // Output register
  logic                  out_valid_q;
  logic                  kind_q;
  logic [7:0]            nbyte_q;
  logic [CountWidth-1:0] nidx_q;
  logic [AddrWidth-1:0]  oaddr_q;
  logic [7:0]            orssi_q;
  logic [CountWidth-1:0] olen_q;
  logic                  ofound_q, opres_q;

  logic                  in_xfer;
  logic                  emit_name, emit_sum;
  logic [PosWidth-1:0]   d;
  logic                  in_data, in_rssi;
  logic [PosWidth:0]     nfo_p1, nfo_p2, name_end;

  // Accept a new byte whenever the output slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign d       = pos_q - PosData;
  assign in_data = (pos_q >= PosData) && (pos_q != PosSat) && (d < {1'b0, len_q});
  assign in_rssi = (pos_q >= PosData) && (pos_q != PosSat) && (d == {1'b0, len_q});
  assign nfo_p1  = {1'b0, nfo_q} + 10'd1;

  always_comb begin
    hdr_d     = hdr_q;
    addr_d    = addr_q;
    len_d     = len_q;
    nfo_d     = nfo_q;
    fls_d     = fls_q;
    stop_d    = stop_q;
    in_name_d = in_name_q;
    seen_d    = seen_q;
    rssi_d    = rssi_q;
    rssi_ok_d = rssi_ok_q;
    emit_name = 1'b0;

    // Header check on the type, event and subevent bytes
    if ((pos_q == PosType && data_byte_i != PktTypeEvent) ||
        (pos_q == PosEvent && data_byte_i != EvtLeMeta) ||
        (pos_q == PosSubEvt && data_byte_i != SubAdvReport)) begin
      hdr_d = 1'b0;
    end

    // Shift the address in, first byte lowest
    if (pos_q >= PosAddrLo && pos_q <= PosAddrHi) begin
      addr_d = addr_q | ({{(AddrWidth-8){1'b0}}, data_byte_i} << {pos_q - PosAddrLo, 3'b000});
    end

    if (pos_q == PosDataLen) begin
      len_d = data_byte_i;
    end

    // Walk the length-type-value fields until a name field or a zero length
    if (in_data && !stop_q) begin
      if (d == nfo_q) begin
        if (data_byte_i == 8'd0) begin
          stop_d = 1'b1;
        end else begin
          fls_d = data_byte_i;
        end
      end else if ({1'b0, d} == nfo_p1) begin
        if (data_byte_i == AdShortName || data_byte_i == AdCompleteName) begin
          seen_d    = 1'b1;
          in_name_d = 1'b1;
          stop_d    = 1'b1;
        end else begin
          nfo_d = nfo_q + {1'b0, fls_q} + 9'd1;
        end
      end
    end

    nfo_p2   = {1'b0, nfo_d} + 10'd2;
    name_end = {1'b0, nfo_d} + 10'd1 + {2'b00, fls_d};

    // Stream name bytes that lie inside both the name field and the data
    if (in_data && in_name_d && hdr_d && !packet_end_i &&
        {1'b0, d} >= nfo_p2 && {1'b0, d} < name_end && cnt_q < MaxNameC) begin
      emit_name = 1'b1;
    end

    if (in_rssi) begin
      rssi_d    = data_byte_i;
      rssi_ok_d = 1'b1;
    end

    emit_sum = packet_end_i && hdr_d && (pos_q >= PosSubEvt);
    cnt_d    = emit_name ? cnt_q + 5'd1 : cnt_q;
    pos_d    = (pos_q == PosSat) ? pos_q : pos_q + 9'd1;
  end

  // Parse state: advance on each transfer, return to start after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_q     <= 1'b1;
      addr_q    <= '0;
      len_q     <= '0;
      nfo_q     <= '0;
      fls_q     <= '0;
      stop_q    <= 1'b0;
      in_name_q <= 1'b0;
      cnt_q     <= '0;
      seen_q    <= 1'b0;
      rssi_q    <= '0;
      rssi_ok_q <= 1'b0;
    end else if (in_xfer) begin
      if (packet_end_i) begin
        pos_q     <= '0;
        hdr_q     <= 1'b1;
        addr_q    <= '0;
        len_q     <= '0;
        nfo_q     <= '0;
        fls_q     <= '0;
        stop_q    <= 1'b0;
        in_name_q <= 1'b0;
        cnt_q     <= '0;
        seen_q    <= 1'b0;
        rssi_q    <= '0;
        rssi_ok_q <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        hdr_q     <= hdr_d;
        addr_q    <= addr_d;
        len_q     <= len_d;
        nfo_q     <= nfo_d;
        fls_q     <= fls_d;
        stop_q    <= stop_d;
        in_name_q <= in_name_d;
        cnt_q     <= cnt_d;
        seen_q    <= seen_d;
        rssi_q    <= rssi_d;
        rssi_ok_q <= rssi_ok_d;
      end
    end
  end

  // Output valid: load on a result, drop once the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= emit_name || emit_sum;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold unless a new result is loaded
  always_ff @(posedge clk_i) begin
    if (in_xfer && (emit_name || emit_sum)) begin
      if (emit_sum) begin
        kind_q   <= KindSummary;
        nbyte_q  <= '0;
        nidx_q   <= '0;
        oaddr_q  <= addr_d;
        orssi_q  <= rssi_d;
        olen_q   <= cnt_q;
        ofound_q <= seen_d;
        opres_q  <= rssi_ok_d;
      end else begin
        kind_q   <= KindNameByte;
        nbyte_q  <= data_byte_i;
        nidx_q   <= cnt_q;
        oaddr_q  <= '0;
        orssi_q  <= '0;
        olen_q   <= '0;
        ofound_q <= 1'b0;
        opres_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign name_byte_o       = nbyte_q;
  assign name_index_o      = nidx_q;
  assign device_address_o  = oaddr_q;
  assign signal_strength_o = $signed(orssi_q);
  assign name_length_o     = olen_q;
  assign name_found_o      = ofound_q;
  assign rssi_present_o    = opres_q;

endmodule

/* test/ble_adv_report_parser_tb.sv */
// Self-checking testbench for ble_adv_report_parser: directed packets, then random HCI traffic.
// A predictor built into this file works out every name byte and summary and checks them.
// Depends on bapr_pkg and the parser RTL.
`timescale 1ns / 100ps

module ble_adv_report_parser_tb;
  import bapr_pkg::*;

  localparam int unsigned NameCap       = MaxNameDef;
  localparam int unsigned ItemsPerPhase = 583;
  localparam int unsigned ShownErrors   = 10;

  // One result as the block presents it; unused fields of a kind are zero.
  typedef struct packed {
    logic                  kind;
    logic [7:0]            name_byte;
    logic [CountWidth-1:0] name_index;
    logic [AddrWidth-1:0]  address;
    logic signed [7:0]     rssi;
    logic [CountWidth-1:0] name_total;
    logic                  name_found;
    logic                  rssi_present;
  } adv_report_t;

  // One directed byte; has_fixed marks a row whose result is typed in below.
  typedef struct packed {
    logic [7:0]  data;
    logic        is_end;
    logic        has_fixed;
    adv_report_t fixed_rep;
  } stim_row_t;

  localparam adv_report_t NoReport = '0;
  localparam adv_report_t EmptySummary =
      '{KindSummary, 8'h00, 5'd0, 48'h0, 8'sh00, 5'd0, 1'b0, 1'b0};
  localparam adv_report_t NameFirst =
      '{KindNameByte, 8'hFF, 5'd0, 48'h0, 8'sh00, 5'd0, 1'b0, 1'b0};
  localparam adv_report_t NameSecond =
      '{KindNameByte, 8'h00, 5'd1, 48'h0, 8'sh00, 5'd0, 1'b0, 1'b0};
  localparam adv_report_t FullSummary =
      '{KindSummary, 8'h00, 5'd0, 48'hFFFF_FFFF_FFFF, 8'sh80, 5'd2, 1'b1, 1'b1};

  localparam int unsigned DirRows = 24;
  localparam stim_row_t DirectedRows [DirRows] = '{
    // lone type byte closing the packet: too short for a summary
    '{PktTypeEvent,   1'b1, 1'b0, NoReport},
    // bare header ending on the subevent: summary with nothing captured
    '{PktTypeEvent,   1'b0, 1'b0, NoReport},
    '{EvtLeMeta,      1'b0, 1'b0, NoReport},
    '{8'h00,          1'b0, 1'b0, NoReport},
    '{SubAdvReport,   1'b1, 1'b1, EmptySummary},
    // full report: all-ones address, two-byte name of extreme values, RSSI -128
    '{PktTypeEvent,   1'b0, 1'b0, NoReport},
    '{EvtLeMeta,      1'b0, 1'b0, NoReport},
    '{8'h7F,          1'b0, 1'b0, NoReport},
    '{SubAdvReport,   1'b0, 1'b0, NoReport},
    '{8'h00,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'h00,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b0, NoReport},
    '{8'h04,          1'b0, 1'b0, NoReport},
    '{8'h03,          1'b0, 1'b0, NoReport},
    '{AdCompleteName, 1'b0, 1'b0, NoReport},
    '{8'hFF,          1'b0, 1'b1, NameFirst},
    '{8'h00,          1'b0, 1'b1, NameSecond},
    '{8'h80,          1'b1, 1'b1, FullSummary}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i  = 8'h00;
  logic                  packet_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  kind_o;
  logic [7:0]            name_byte_o;
  logic [CountWidth-1:0] name_index_o;
  logic [AddrWidth-1:0]  device_address_o;
  logic signed [7:0]     signal_strength_o;
  logic [CountWidth-1:0] name_length_o;
  logic                  name_found_o;
  logic                  rssi_present_o;

  ble_adv_report_parser #(
    .MAX_NAME(NameCap)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .packet_end_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .name_byte_o,
    .name_index_o,
    .device_address_o,
    .signal_strength_o,
    .name_length_o,
    .name_found_o,
    .rssi_present_o
  );

  // Parser state mirrored by the predictor
  logic [PosWidth-1:0]   pos_q;
  logic                  hdr_ok;
  logic [AddrWidth-1:0]  addr_acc;
  logic [7:0]            data_len;
  logic [PosWidth-1:0]   field_off;
  logic [7:0]            field_len;
  logic                  walk_done;
  logic                  in_name;
  logic [CountWidth-1:0] name_cnt;
  logic                  name_seen;
  logic [7:0]            rssi_q;
  logic                  rssi_seen;

  adv_report_t      due_reports [$];
  logic [7:0]       pkt_bytes [$];
  int unsigned      send_gap_pct = 9;
  int unsigned      take_gap_pct = 45;
  int unsigned      error_count  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Return to the start-of-packet state, as after reset or any packet end.
  function automatic void clear_parse_state();
    pos_q     = '0;
    hdr_ok    = 1'b1;
    addr_acc  = '0;
    data_len  = '0;
    field_off = '0;
    field_len = '0;
    walk_done = 1'b0;
    in_name   = 1'b0;
    name_cnt  = '0;
    name_seen = 1'b0;
    rssi_q    = '0;
    rssi_seen = 1'b0;
  endfunction

  // Advance the parser by one byte; return 1 with the result when the byte causes one.
  function automatic bit parse_byte(input logic [7:0] b, input logic is_end,
                                    output adv_report_t rep);
    int unsigned p;
    int unsigned d;
    bit          emit;
    rep  = '0;
    emit = 1'b0;
    p    = pos_q;
    if ((p == PosType && b != PktTypeEvent) || (p == PosEvent && b != EvtLeMeta) ||
        (p == PosSubEvt && b != SubAdvReport)) begin
      hdr_ok = 1'b0;
    end
    if (p >= PosAddrLo && p <= PosAddrHi) begin
      addr_acc |= AddrWidth'(b) << (8 * (p - PosAddrLo));
    end
    if (p == PosDataLen) begin
      data_len = b;
    end
    if (p >= PosData && p < PosSat) begin
      d = p - PosData;
      if (d < data_len) begin
        // Walk the length-type-value chain until a name field or a zero length.
        if (!walk_done) begin
          if (d == field_off) begin
            if (b == 8'h00) walk_done = 1'b1;
            else field_len = b;
          end else if (d == field_off + 1) begin
            if (b == AdShortName || b == AdCompleteName) begin
              name_seen = 1'b1;
              in_name   = 1'b1;
              walk_done = 1'b1;
            end else begin
              field_off = PosWidth'(field_off + field_len + 1);
            end
          end
        end
        // Name bytes lie inside both the field and the data; the last byte never counts.
        if (in_name && hdr_ok && !is_end && d >= field_off + 2 &&
            d < field_off + 1 + field_len && name_cnt < NameCap) begin
          emit           = 1'b1;
          rep.kind       = KindNameByte;
          rep.name_byte  = b;
          rep.name_index = name_cnt;
          name_cnt       = name_cnt + 1'b1;
        end
      end else if (d == data_len) begin
        rssi_q    = b;
        rssi_seen = 1'b1;
      end
    end
    if (is_end) begin
      emit = hdr_ok && p >= PosSubEvt;
      if (emit) begin
        rep              = '0;
        rep.kind         = KindSummary;
        rep.address      = addr_acc;
        rep.rssi         = rssi_q;
        rep.name_total   = name_cnt;
        rep.name_found   = name_seen;
        rep.rssi_present = rssi_seen;
      end
      clear_parse_state();
    end else if (p < PosSat) begin
      pos_q = pos_q + 1'b1;
    end
    return emit;
  endfunction

  function automatic string fmt_report(adv_report_t r);
    return $sformatf("kind=%0d byte=%h idx=%0d addr=%h rssi=%0d len=%0d name=%0b rssi_ok=%0b",
                     r.kind, r.name_byte, r.name_index, r.address, r.rssi, r.name_total,
                     r.name_found, r.rssi_present);
  endfunction

  function automatic void flag_error(string what);
    error_count++;
    if (error_count <= ShownErrors) $display("%0t: %s", $realtime, what);
  endfunction

  // Build one random packet into pkt_bytes. Most are well-formed reports with random
  // content; the rest are noise, broken headers, short data lengths and cut packets.
  function automatic void make_packet(input bit stretch);
    int unsigned roll;
    int unsigned flen;
    int unsigned dlen;
    int unsigned keep;
    int unsigned bad_pos;
    logic [7:0]  ad [$];
    pkt_bytes.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24)) pkt_bytes.push_back(8'($urandom()));
      return;
    end
    pkt_bytes.push_back(PktTypeEvent);
    pkt_bytes.push_back(EvtLeMeta);
    pkt_bytes.push_back(8'($urandom()));
    pkt_bytes.push_back(SubAdvReport);
    // report count, event type, address type, then the six address bytes
    repeat (9) pkt_bytes.push_back(8'($urandom()));
    repeat ($urandom_range(0, 2)) begin
      flen = $urandom_range(1, 4);
      ad.push_back(8'(flen));
      repeat (flen) ad.push_back(8'($urandom()));
    end
    // zero-length field: stops the walk ahead of any name
    if ($urandom_range(0, 9) == 0) ad.push_back(8'h00);
    if ($urandom_range(0, 9) != 0) begin
      flen = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 10);
      ad.push_back(8'(flen + 1));
      ad.push_back($urandom_range(0, 1) ? AdShortName : AdCompleteName);
      repeat (flen) ad.push_back(8'($urandom()));
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // data length short of the fields: type or name bytes fall outside
      dlen = $urandom_range(0, ad.size());
    end else begin
      if (roll < 25) repeat ($urandom_range(1, 4)) ad.push_back(8'($urandom()));
      dlen = ad.size();
      ad.push_back(8'($urandom()));
    end
    pkt_bytes.push_back(8'(dlen));
    foreach (ad[i]) pkt_bytes.push_back(ad[i]);
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom()));
    if (stretch) begin
      // run the position counter into saturation
      keep = $urandom_range(512, 530);
      while (pkt_bytes.size() < keep) pkt_bytes.push_back(8'($urandom()));
    end else if ($urandom_range(0, 6) == 0) begin
      keep = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0:       bad_pos = PosType;
        1:       bad_pos = PosEvent;
        default: bad_pos = PosSubEvt;
      endcase
      if (bad_pos < pkt_bytes.size()) pkt_bytes[bad_pos] ^= 8'($urandom_range(1, 255));
    end
  endfunction

  // Offer one byte, hold it until the transfer, then queue what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic is_end, input logic has_fixed,
                           input adv_report_t fixed_rep);
    adv_report_t rep;
    bit          has_rep;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    packet_end_i <= is_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_rep = parse_byte(b, is_end, rep);
    if (has_fixed) due_reports.push_back(fixed_rep);
    else if (has_rep) due_reports.push_back(rep);
  endtask

  // Take results with random stalls and compare each with the oldest expectation.
  always @(posedge clk_i) begin : take_reports
    adv_report_t got;
    adv_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, name_byte_o, name_index_o, device_address_o, signal_strength_o,
              name_length_o, name_found_o, rssi_present_o};
      if (due_reports.size() == 0) begin
        flag_error({"result with nothing expected: ", fmt_report(got)});
      end else begin
        want = due_reports.pop_front();
        if (got.kind !== want.kind || got.name_byte !== want.name_byte ||
            got.name_index !== want.name_index || got.address !== want.address ||
            got.rssi !== want.rssi || got.name_total !== want.name_total ||
            got.name_found !== want.name_found || got.rssi_present !== want.rssi_present) begin
          flag_error({"mismatch: expected ", fmt_report(want), " got ", fmt_report(got)});
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= take_gap_pct);
  end

  initial begin : drive_packets
    int unsigned phase_items;
    int unsigned drain_cycles;
    clear_parse_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < DirRows; i++) begin
      send_byte(DirectedRows[i].data, DirectedRows[i].is_end, DirectedRows[i].has_fixed,
                DirectedRows[i].fixed_rep);
    end

    // Three idling mixes: receiver sparse, sender sparse, then full rate both ways.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 9;  take_gap_pct = 45; end
        1:       begin send_gap_pct = 45; take_gap_pct = 9;  end
        default: begin send_gap_pct = 0;  take_gap_pct = 0;  end
      endcase
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        make_packet(phase == 0 && phase_items == 0);
        foreach (pkt_bytes[i]) begin
          send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, NoReport);
        end
        phase_items += pkt_bytes.size();
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every queued result, then keep taking results to catch strays.
    drain_cycles = 0;
    while (due_reports.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (due_reports.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", due_reports.size()));
    end
    if (error_count == 0) begin
      $display("PASS ble_adv_report_parser");
    end else begin
      $display("FAIL ble_adv_report_parser");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL ble_adv_report_parser");
    $finish;
  end

endmodule

/* files.f */
rtl/bapr_pkg.sv
rtl/ble_adv_report_parser.sv
test/ble_adv_report_parser_tb.sv
